[design/rgbhf_pkg.sv]
// Shared types, codes and tables of the RGB LED hue fade controller.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rgbhf_pkg;

  // Fixed sizes
  localparam int LED_SLOTS = 16;
  localparam int MAX_OUT   = 16;
  localparam int HUE_W     = 10;
  localparam int CNT_W     = 5;
  localparam int IDX_W     = 4;
  localparam int LVL_W     = 4;

  localparam logic [HUE_W-1:0] HUE_SPAN = 10'd768;

  // Level map
  localparam logic [LVL_W-1:0] WHITE_LEVEL   = 4'd7;
  localparam logic [LVL_W-1:0] RAINBOW_LEVEL = 4'd9;
  localparam logic [LVL_W-1:0] TOP_LEVEL     = 4'd9;

  // Event codes
  localparam logic [3:0] MODE_INIT   = 4'd0;
  localparam logic [3:0] MODE_TICK   = 4'd1;
  localparam logic [3:0] MODE_TOGGLE = 4'd2;
  localparam logic [3:0] MODE_ON     = 4'd3;
  localparam logic [3:0] MODE_OFF    = 4'd4;
  localparam logic [3:0] MODE_UP     = 4'd5;
  localparam logic [3:0] MODE_DOWN   = 4'd6;
  localparam logic [3:0] MODE_STEP   = 4'd7;
  localparam logic [3:0] MODE_SETB   = 4'd8;
  localparam logic [3:0] MODE_RAISE  = 4'd9;
  localparam logic [3:0] MODE_LOWER  = 4'd10;

  // Register indexes
  localparam logic [2:0] REG_LED_COUNT    = 3'd0;
  localparam logic [2:0] REG_BRIGHT_FLOOR = 3'd1;
  localparam logic [2:0] REG_BRIGHT_CEIL  = 3'd2;
  localparam logic [2:0] REG_SAVED_LEVEL  = 3'd3;
  localparam logic [2:0] REG_SAVED_ENABLE = 3'd4;
  localparam logic [2:0] REG_SAVED_BRIGHT = 3'd5;

  typedef struct packed {
    logic [CNT_W-1:0] led_count;
    logic [7:0]       bright_floor;
    logic [7:0]       bright_ceil;
    logic [LVL_W-1:0] saved_level;
    logic             saved_enable;
    logic [7:0]       saved_bright;
  } cfg_t;

  // Lighting state the refresh burst reads
  typedef struct packed {
    logic [HUE_W-1:0] hue_base;
    logic [7:0]       sat;
    logic [7:0]       drive;
    logic             rainbow;
  } lite_t;

  // Hue spacing between neighboring LEDs in rainbow mode: 768 / count
  function automatic logic [HUE_W-1:0] rainbow_step(input logic [CNT_W-1:0] cnt);
    logic [HUE_W-1:0] s;
    case (cnt)
      5'd1:    s = 10'd768;
      5'd2:    s = 10'd384;
      5'd3:    s = 10'd256;
      5'd4:    s = 10'd192;
      5'd5:    s = 10'd153;
      5'd6:    s = 10'd128;
      5'd7:    s = 10'd109;
      5'd8:    s = 10'd96;
      5'd9:    s = 10'd85;
      5'd10:   s = 10'd76;
      5'd11:   s = 10'd69;
      5'd12:   s = 10'd64;
      5'd13:   s = 10'd59;
      5'd14:   s = 10'd54;
      5'd15:   s = 10'd51;
      5'd16:   s = 10'd48;
      default: s = 10'd0;
    endcase
    return s;
  endfunction

  // Fixed hue of a static color level: ((lv - 1) * 128) mod 768
  function automatic logic [HUE_W-1:0] level_hue(input logic [LVL_W-1:0] lv);
    logic [LVL_W-1:0] v;
    logic [LVL_W-1:0] r;
    v = lv - 4'd1;
    if (v >= 4'd12) begin
      r = v - 4'd12;
    end else if (v >= 4'd6) begin
      r = v - 4'd6;
    end else begin
      r = v;
    end
    return {r[2:0], 7'b0};
  endfunction

endpackage

`default_nettype wire

[design/rgb_led_hue_fade_controller.sv]
// RGB LED hue fade controller: one event request in, a burst of LED colors out.
// An event is taken only while the block is idle. An event that refreshes no
// colors leaves the block idle and ready for the next event; a refresh with no
// active LEDs goes back to idle from the load state. A refresh emits one color
// per active LED (min(led_count, LED_SLOTS, 16)): each color needs three passes
// through the single shared 9x8 multiplier of the conversion unit, a done phase
// and a hand-over to the output register. The next color is computed while one
// still waits there; a color that is still waiting holds the hand-over of the
// next. Depends on rgbhf_pkg, rgbhf_regs, rgbhf_ctrl and rgbhf_hsb.
`default_nettype none

module rgb_led_hue_fade_controller #(
  parameter int                          LED_SLOTS     = rgbhf_pkg::LED_SLOTS,
  parameter logic [rgbhf_pkg::LVL_W-1:0] WHITE_LEVEL   = rgbhf_pkg::WHITE_LEVEL,
  parameter logic [rgbhf_pkg::LVL_W-1:0] RAINBOW_LEVEL = rgbhf_pkg::RAINBOW_LEVEL,
  parameter logic [rgbhf_pkg::LVL_W-1:0] TOP_LEVEL     = rgbhf_pkg::TOP_LEVEL
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [3:0]   mode_i,
  input  wire logic [7:0]   value_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [3:0]        led_index_o,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic              last_o
);

  localparam int HW  = rgbhf_pkg::HUE_W;
  localparam int CW  = rgbhf_pkg::CNT_W;
  localparam int IW  = rgbhf_pkg::IDX_W;
  localparam int CAP = (LED_SLOTS < rgbhf_pkg::MAX_OUT) ?
                       LED_SLOTS : rgbhf_pkg::MAX_OUT;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  rgbhf_pkg::cfg_t  cfg;
  rgbhf_pkg::lite_t lite;

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [HW-1:0] hue_q, hue_d;
  logic [HW-1:0] step_q, step_d;
  logic          out_valid_q, out_valid_d;
  logic [IW-1:0] out_idx_q;
  logic [7:0]    out_r_q, out_g_q, out_b_q;
  logic          out_last_q;

  logic          in_fire;
  logic          evt_refresh;
  logic [CW-1:0] act_cnt;
  logic [HW:0]   hue_sum;
  logic [HW-1:0] hue_nxt;
  logic          is_last;
  logic          out_free;
  logic          load_out;
  logic          conv_start;
  logic [HW-1:0] conv_hue;
  logic          conv_done;
  logic [7:0]    conv_r, conv_g, conv_b;

  rgbhf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  rgbhf_ctrl #(
    .WHITE_LEVEL   (WHITE_LEVEL),
    .RAINBOW_LEVEL (RAINBOW_LEVEL),
    .TOP_LEVEL     (TOP_LEVEL)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .evt_en_i  (in_fire),
    .mode_i    (mode_i),
    .value_i   (value_i),
    .cfg_i     (cfg),
    .refresh_o (evt_refresh),
    .lite_o    (lite)
  );

  assign act_cnt  = (cfg.led_count > CW'(CAP)) ? CW'(CAP) : cfg.led_count;
  assign hue_sum  = {1'b0, hue_q} + {1'b0, step_q};
  assign hue_nxt  = (hue_sum >= {1'b0, rgbhf_pkg::HUE_SPAN}) ?
                    HW'(hue_sum - {1'b0, rgbhf_pkg::HUE_SPAN}) : hue_sum[HW-1:0];
  assign is_last  = (({1'b0, idx_q} + CW'(1)) == cnt_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign load_out = (state_q == S_EMIT) && out_free;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    hue_d      = hue_q;
    step_d     = step_q;
    conv_start = 1'b0;
    conv_hue   = hue_nxt;
    case (state_q)
      S_IDLE: begin
        if (in_fire && evt_refresh) state_d = S_LOAD;
      end
      S_LOAD: begin
        // lighting state now holds the event's result
        if (act_cnt != '0) begin
          conv_start = 1'b1;
          conv_hue   = lite.hue_base;
          cnt_d      = act_cnt;
          idx_d      = '0;
          hue_d      = lite.hue_base;
          step_d     = lite.rainbow ? rgbhf_pkg::rainbow_step(act_cnt) : '0;
          state_d    = S_WAIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WAIT: begin
        if (conv_done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            conv_start = 1'b1;
            idx_d      = idx_q + IW'(1);
            hue_d      = hue_nxt;
            state_d    = S_WAIT;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  rgbhf_hsb u_hsb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .hue_i    (conv_hue),
    .sat_i    (lite.sat),
    .bright_i (lite.drive),
    .done_o   (conv_done),
    .red_o    (conv_r),
    .green_o  (conv_g),
    .blue_o   (conv_b)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    hue_q  <= hue_d;
    step_q <= step_d;
    if (load_out) begin
      out_idx_q  <= idx_q;
      out_r_q    <= conv_r;
      out_g_q    <= conv_g;
      out_b_q    <= conv_b;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_index_o = out_idx_q;
  assign red_o       = out_r_q;
  assign green_o     = out_g_q;
  assign blue_o      = out_b_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

[design/rgbhf_regs.sv]
// APB configuration registers of the hue fade controller.
// Depends on rgbhf_pkg for the register map and the cfg_t struct.
`default_nettype none

module rgbhf_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output rgbhf_pkg::cfg_t    cfg_o
);

  rgbhf_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]      reg_idx;
  logic            wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        rgbhf_pkg::REG_LED_COUNT:    cfg_d.led_count    = pwdata[4:0];
        rgbhf_pkg::REG_BRIGHT_FLOOR: cfg_d.bright_floor = pwdata[7:0];
        rgbhf_pkg::REG_BRIGHT_CEIL:  cfg_d.bright_ceil  = pwdata[7:0];
        rgbhf_pkg::REG_SAVED_LEVEL:  cfg_d.saved_level  = pwdata[3:0];
        rgbhf_pkg::REG_SAVED_ENABLE: cfg_d.saved_enable = pwdata[0];
        rgbhf_pkg::REG_SAVED_BRIGHT: cfg_d.saved_bright = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rgbhf_pkg::REG_LED_COUNT:    prdata = {27'b0, cfg_q.led_count};
      rgbhf_pkg::REG_BRIGHT_FLOOR: prdata = {24'b0, cfg_q.bright_floor};
      rgbhf_pkg::REG_BRIGHT_CEIL:  prdata = {24'b0, cfg_q.bright_ceil};
      rgbhf_pkg::REG_SAVED_LEVEL:  prdata = {28'b0, cfg_q.saved_level};
      rgbhf_pkg::REG_SAVED_ENABLE: prdata = {31'b0, cfg_q.saved_enable};
      rgbhf_pkg::REG_SAVED_BRIGHT: prdata = {24'b0, cfg_q.saved_bright};
      default:                     prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.led_count    <= 5'd16;
      cfg_q.bright_floor <= 8'd16;
      cfg_q.bright_ceil  <= 8'd255;
      cfg_q.saved_level  <= 4'd0;
      cfg_q.saved_enable <= 1'b0;
      cfg_q.saved_bright <= 8'd128;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[design/rgbhf_ctrl.sv]
// Event decoder and lighting state (level, enable, brightness, hue, fade).
// Depends on rgbhf_pkg for event codes, level map and the cfg_t/lite_t structs.
`default_nettype none

module rgbhf_ctrl #(
  parameter logic [rgbhf_pkg::LVL_W-1:0] WHITE_LEVEL   = rgbhf_pkg::WHITE_LEVEL,
  parameter logic [rgbhf_pkg::LVL_W-1:0] RAINBOW_LEVEL = rgbhf_pkg::RAINBOW_LEVEL,
  parameter logic [rgbhf_pkg::LVL_W-1:0] TOP_LEVEL     = rgbhf_pkg::TOP_LEVEL
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  evt_en_i,
  input  wire logic [3:0]            mode_i,
  input  wire logic [7:0]            value_i,
  input  wire rgbhf_pkg::cfg_t       cfg_i,
  output logic                       refresh_o,
  output rgbhf_pkg::lite_t           lite_o
);

  localparam int HW = rgbhf_pkg::HUE_W;
  localparam int LW = rgbhf_pkg::LVL_W;

  logic [LW-1:0] level_q, level_d;
  logic          en_q, en_d;
  logic [7:0]    bright_q, bright_d;
  logic [HW-1:0] hue_q, hue_d;
  logic [7:0]    sat_q, sat_d;
  logic [7:0]    drive_q, drive_d;
  logic          fading_q, fading_d;
  logic          rainbow_q, rainbow_d;
  logic [1:0]    tick_q, tick_d;
  logic [HW-1:0] fade_q, fade_d;
  logic          started_q, started_d;

  logic [LW-1:0] lvn;
  logic [LW:0]   lvs;
  logic [LW-1:0] apply_lv;
  logic          do_apply;
  logic          do_bright;
  logic [7:0]    bright_v;
  logic [8:0]    bsum;
  logic [1:0]    tp;
  logic [HW:0]   fade_inc;
  logic          refresh;

  function automatic logic [7:0] clamp(input logic [7:0] v, input logic [7:0] lo,
                                       input logic [7:0] hi);
    logic [7:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign tp       = tick_q + 2'd1;
  assign fade_inc = {1'b0, fade_q} + 11'd1;
  assign lvs      = {1'b0, level_q} + 5'd1;

  always_comb begin
    level_d   = level_q;
    en_d      = en_q;
    bright_d  = bright_q;
    hue_d     = hue_q;
    sat_d     = sat_q;
    drive_d   = drive_q;
    fading_d  = fading_q;
    rainbow_d = rainbow_q;
    tick_d    = tick_q;
    fade_d    = fade_q;
    started_d = started_q;
    refresh   = 1'b0;
    do_apply  = 1'b0;
    do_bright = 1'b0;
    apply_lv  = level_q;
    lvn       = level_q;
    bright_v  = bright_q;
    bsum      = 9'd0;

    case (mode_i)
      rgbhf_pkg::MODE_INIT: begin
        hue_d     = '0;
        sat_d     = 8'd255;
        drive_d   = cfg_i.bright_floor;
        level_d   = cfg_i.saved_level;
        en_d      = cfg_i.saved_enable;
        bright_d  = clamp(cfg_i.saved_bright, cfg_i.bright_floor, cfg_i.bright_ceil);
        apply_lv  = cfg_i.saved_enable ? cfg_i.saved_level : '0;
        do_apply  = 1'b1;
        started_d = 1'b1;
      end
      rgbhf_pkg::MODE_TICK: begin
        if (fading_q) begin
          if (tp > 2'd1) begin
            // fade step: show the current fade hue, then advance it
            tick_d  = 2'd0;
            hue_d   = fade_q;
            refresh = 1'b1;
            fade_d  = (fade_inc >= {1'b0, rgbhf_pkg::HUE_SPAN}) ? '0 : fade_inc[HW-1:0];
          end else begin
            tick_d = tp;
          end
        end
      end
      rgbhf_pkg::MODE_TOGGLE, rgbhf_pkg::MODE_ON, rgbhf_pkg::MODE_OFF: begin
        do_apply = 1'b1;
        if (mode_i == rgbhf_pkg::MODE_OFF || (mode_i == rgbhf_pkg::MODE_TOGGLE && en_q)) begin
          en_d     = 1'b0;
          apply_lv = '0;
        end else begin
          en_d     = 1'b1;
          lvn      = (level_q == '0) ? 4'd1 : level_q;
          level_d  = lvn;
          apply_lv = lvn;
        end
      end
      rgbhf_pkg::MODE_UP: begin
        do_apply = 1'b1;
        if (level_q < TOP_LEVEL) begin
          lvn  = lvs[LW-1:0];
          en_d = 1'b1;
        end
        level_d  = lvn;
        apply_lv = lvn;
      end
      rgbhf_pkg::MODE_DOWN: begin
        do_apply = 1'b1;
        if (level_q != '0) begin
          lvn  = level_q - 4'd1;
          en_d = (lvn != '0);
        end
        level_d  = lvn;
        apply_lv = lvn;
      end
      rgbhf_pkg::MODE_STEP: begin
        do_apply = 1'b1;
        lvn      = (lvs > {1'b0, TOP_LEVEL}) ? '0 : lvs[LW-1:0];
        en_d     = (lvn != '0);
        level_d  = lvn;
        apply_lv = lvn;
      end
      rgbhf_pkg::MODE_SETB: begin
        do_bright = 1'b1;
        bright_v  = value_i;
      end
      rgbhf_pkg::MODE_RAISE: begin
        do_bright = 1'b1;
        bsum      = {1'b0, bright_q} + {1'b0, value_i};
        bright_v  = (bsum > {1'b0, cfg_i.bright_ceil}) ? cfg_i.bright_ceil : bsum[7:0];
      end
      rgbhf_pkg::MODE_LOWER: begin
        do_bright = 1'b1;
        bsum      = {1'b0, cfg_i.bright_floor} + {1'b0, value_i};
        bright_v  = ({1'b0, bright_q} < bsum) ? cfg_i.bright_floor : bright_q - value_i;
      end
      default: ;
    endcase

    // Brightness changes count only after init
    if (do_bright && started_q) begin
      bright_d = clamp(bright_v, cfg_i.bright_floor, cfg_i.bright_ceil);
      if (en_q) begin
        drive_d = bright_d;
        refresh = 1'b1;
      end
    end

    if (do_apply) begin
      drive_d = (apply_lv == '0) ? 8'd0 : bright_d;
      if (apply_lv <= WHITE_LEVEL) begin
        fading_d  = 1'b0;
        rainbow_d = 1'b0;
        refresh   = 1'b1;
        if (apply_lv != '0) begin
          if (apply_lv == WHITE_LEVEL) begin
            sat_d = 8'd0;
          end else begin
            hue_d = rgbhf_pkg::level_hue(apply_lv);
            sat_d = 8'd255;
          end
        end
      end else begin
        sat_d     = 8'd255;
        fading_d  = 1'b1;
        rainbow_d = (apply_lv >= RAINBOW_LEVEL);
      end
    end
  end

  assign refresh_o      = refresh;
  assign lite_o.hue_base = hue_q;
  assign lite_o.sat      = sat_q;
  assign lite_o.drive    = drive_q;
  assign lite_o.rainbow  = rainbow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= '0;
      en_q      <= 1'b0;
      bright_q  <= 8'd16;
      hue_q     <= '0;
      sat_q     <= 8'd255;
      drive_q   <= 8'd16;
      fading_q  <= 1'b0;
      rainbow_q <= 1'b0;
      tick_q    <= 2'd0;
      fade_q    <= '0;
      started_q <= 1'b0;
    end else if (evt_en_i) begin
      level_q   <= level_d;
      en_q      <= en_d;
      bright_q  <= bright_d;
      hue_q     <= hue_d;
      sat_q     <= sat_d;
      drive_q   <= drive_d;
      fading_q  <= fading_d;
      rainbow_q <= rainbow_d;
      tick_q    <= tick_d;
      fade_q    <= fade_d;
      started_q <= started_d;
    end
  end

endmodule

`default_nettype wire

[design/rgbhf_hsb.sv]
// Constant-brightness HSB to RGB conversion on one shared 9x8 multiplier.
// Three multiply passes per color under a small phase counter; uses rgbhf_pkg.
`default_nettype none

module rgbhf_hsb (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rgbhf_pkg::HUE_W-1:0] hue_i,
  input  wire logic [7:0]                  sat_i,
  input  wire logic [7:0]                  bright_i,
  output logic                             done_o,
  output logic [7:0]                       red_o,
  output logic [7:0]                       green_o,
  output logic [7:0]                       blue_o
);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_FRAC = 3'd1;
  localparam logic [2:0] P_X    = 3'd2;
  localparam logic [2:0] P_M    = 3'd3;
  localparam logic [2:0] P_DONE = 3'd4;

  logic [2:0]                  phase_q, phase_d;
  logic [rgbhf_pkg::HUE_W-1:0] hue_q;
  logic [7:0]                  sat_q, br_q;
  logic [7:0]                  t_q, x_q, m_q;
  logic [8:0]                  mul_a;
  logic [7:0]                  mul_b;
  logic [16:0]                 prod;
  logic [7:0]                  xm, bx;

  // Operand select for the shared multiplier
  always_comb begin
    case (phase_q)
      P_FRAC: begin
        mul_a = {1'b0, hue_q[7:0]};
        mul_b = sat_q;
      end
      P_X: begin
        mul_a = {1'b0, t_q};
        mul_b = br_q;
      end
      P_M: begin
        mul_a = 9'd256 - {1'b0, sat_q};
        mul_b = br_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = {8'b0, mul_a} * {9'b0, mul_b};

  always_comb begin
    case (phase_q)
      P_IDLE:  phase_d = start_i ? P_FRAC : P_IDLE;
      P_FRAC:  phase_d = P_X;
      P_X:     phase_d = P_M;
      P_M:     phase_d = P_DONE;
      default: phase_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == P_IDLE && start_i) begin
      hue_q <= hue_i;
      sat_q <= sat_i;
      br_q  <= bright_i;
    end
    if (phase_q == P_FRAC) t_q <= prod[15:8];
    if (phase_q == P_X)    x_q <= prod[15:8];
    if (phase_q == P_M)    m_q <= prod[15:8];
  end

  assign done_o = (phase_q == P_DONE);
  assign xm     = x_q + m_q;
  assign bx     = br_q - x_q;

  // Pick from the ring {m, x+m, b-x, m, x+m} by hue sector
  always_comb begin
    case (hue_q[9:8])
      2'd1: begin
        red_o   = m_q;
        green_o = bx;
        blue_o  = xm;
      end
      2'd2: begin
        red_o   = xm;
        green_o = m_q;
        blue_o  = bx;
      end
      default: begin
        red_o   = bx;
        green_o = xm;
        blue_o  = m_q;
      end
    endcase
  end

endmodule

`default_nettype wire
